### rtl/complex_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CAU_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cau check failed");

// antecedent implies consequent after a delay of n
`define CAU_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("cau latency check failed");

`endif

### rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared constants, codes and types of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS   = 16;
  localparam int FRAC_BITS   = 8;
  localparam int MODE_BITS   = 3;
  localparam int STAT_BITS   = 2;
  localparam int AS_BITS     = WORD_BITS + 1;
  localparam int PROD_BITS   = 2 * WORD_BITS;
  localparam int SUM_BITS    = PROD_BITS + 1;
  localparam int QUO_BITS    = WORD_BITS + 1;
  localparam int DIVD_BITS   = PROD_BITS + FRAC_BITS + 1;
  localparam int SRT_BITS    = WORD_BITS + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  // front reg, queue, four mac stages, one stage per quotient bit, output reg
  localparam int LATENCY     = QUO_BITS + 7;

  localparam logic [MODE_BITS-1:0] MODE_ADD = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_SUB = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_MUL = MODE_BITS'(2);
  localparam logic [MODE_BITS-1:0] MODE_DIV = MODE_BITS'(3);
  localparam logic [MODE_BITS-1:0] MODE_MAG = MODE_BITS'(4);

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [QUO_BITS-1:0] POS_MAX = {2'b00, {(WORD_BITS-1){1'b1}}};
  localparam logic [QUO_BITS-1:0] NEG_MAG = {2'b01, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MAG,
    OP_NONE
  } op_e;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_e;

  typedef struct packed {
    op_e   op;
    word_t a_re;
    word_t a_im;
    word_t b_re;
    word_t b_im;
  } item_t;

  // everything one item carries through the iterative back end
  typedef struct packed {
    op_e                  op;
    logic                 den_zero;
    logic                 neg_re;
    logic                 neg_im;
    logic                 big_re;
    logic                 big_im;
    logic [QUO_BITS-1:0]  mag_re;
    logic [QUO_BITS-1:0]  mag_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic [PROD_BITS-1:0] den;
    logic [PROD_BITS-1:0] rem_re;
    logic [PROD_BITS-1:0] rem_im;
    logic [QUO_BITS-1:0]  low_re;
    logic [QUO_BITS-1:0]  low_im;
    logic [QUO_BITS-1:0]  q_re;
    logic [QUO_BITS-1:0]  q_im;
    logic [PROD_BITS-1:0] srad;
    logic [SRT_BITS-1:0]  srem;
    logic [WORD_BITS-1:0] sroot;
  } stage_t;

endpackage

### rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// accepts transactions and decodes the mode into an operation
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [MODE_BITS-1:0] mode_i,
  input  word_t                a_re_i,
  input  word_t                a_im_i,
  input  word_t                b_re_i,
  input  word_t                b_im_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output item_t                item_o
);

  logic  fv_q, fv_d;
  item_t item_q, item_d;
  op_e   op;
  logic  accept;

  always_comb begin
    unique case (mode_i)
      MODE_ADD: op = OP_ADD;
      MODE_SUB: op = OP_SUB;
      MODE_MUL: op = OP_MUL;
      MODE_DIV: op = OP_DIV;
      MODE_MAG: op = OP_MAG;
      default:  op = OP_NONE;
    endcase
  end

  assign push_o = fv_q && !q_full_i;
  assign busy_o = fv_q && q_full_i;
  assign accept = start_i && !busy_o;

  always_comb begin
    fv_d   = fv_q;
    item_d = item_q;
    if (accept) begin
      fv_d   = 1'b1;
      item_d = '{op: op, a_re: a_re_i, a_im: a_im_i, b_re: b_re_i, b_im: b_im_i};
    end else if (push_o) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o = item_q;

endmodule

### rtl/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue
// short fifo between the front and the back end
// ----------------------------------------------------------------------------
module cau_queue import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  item_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign full_o  = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  // the back end never stalls, so the head leaves as soon as it is there
  assign pop     = valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + QCNT_BITS'(1);
      2'b01:   cnt_d = cnt_q - QCNT_BITS'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/cau_mac.sv
// ----------------------------------------------------------------------------
// cau_mac
// products, sums of products and setup of the divide and root iterations
// ----------------------------------------------------------------------------
module cau_mac import cau_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  item_t  item_i,
  output logic   valid_o,
  output stage_t stage_o
);

  localparam logic [PROD_BITS:0] HALF = (PROD_BITS+1)'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    op_e                         op;
    logic signed [PROD_BITS-1:0] m0;
    logic signed [PROD_BITS-1:0] m1;
    logic signed [PROD_BITS-1:0] m2;
    logic signed [PROD_BITS-1:0] m3;
    logic signed [PROD_BITS-1:0] m4;
    logic signed [PROD_BITS-1:0] m5;
    logic signed [AS_BITS-1:0]   as_re;
    logic signed [AS_BITS-1:0]   as_im;
  } prod_t;

  typedef struct packed {
    op_e                        op;
    logic signed [SUM_BITS-1:0] sre;
    logic signed [SUM_BITS-1:0] sim;
    logic [PROD_BITS-1:0]       den;
    logic signed [AS_BITS-1:0]  as_re;
    logic signed [AS_BITS-1:0]  as_im;
  } sum_t;

  typedef struct packed {
    op_e                  op;
    logic                 neg_re;
    logic                 neg_im;
    logic [PROD_BITS-1:0] mag_re;
    logic [PROD_BITS-1:0] mag_im;
    logic [PROD_BITS-1:0] den;
    logic                 den_zero;
  } abs_t;

  logic   pv_q, sv_q, av_q, ov_q;
  prod_t  p_q, p_d;
  sum_t   s_q, s_d;
  abs_t   a_q, a_d;
  stage_t o_q, o_d;
  word_t  y0, y1;

  // products; magnitude reuses the first two multipliers for the squares
  always_comb begin
    y0       = (item_i.op == OP_MAG) ? item_i.a_re : item_i.b_re;
    y1       = (item_i.op == OP_MAG) ? item_i.a_im : item_i.b_im;
    p_d.op   = item_i.op;
    p_d.m0   = PROD_BITS'(item_i.a_re) * PROD_BITS'(y0);
    p_d.m1   = PROD_BITS'(item_i.a_im) * PROD_BITS'(y1);
    p_d.m2   = PROD_BITS'(item_i.a_im) * PROD_BITS'(item_i.b_re);
    p_d.m3   = PROD_BITS'(item_i.a_re) * PROD_BITS'(item_i.b_im);
    p_d.m4   = PROD_BITS'(item_i.b_re) * PROD_BITS'(item_i.b_re);
    p_d.m5   = PROD_BITS'(item_i.b_im) * PROD_BITS'(item_i.b_im);
    if (item_i.op == OP_SUB) begin
      p_d.as_re = AS_BITS'(item_i.a_re) - AS_BITS'(item_i.b_re);
      p_d.as_im = AS_BITS'(item_i.a_im) - AS_BITS'(item_i.b_im);
    end else begin
      p_d.as_re = AS_BITS'(item_i.a_re) + AS_BITS'(item_i.b_re);
      p_d.as_im = AS_BITS'(item_i.a_im) + AS_BITS'(item_i.b_im);
    end
  end

  // exact sums of products
  always_comb begin
    s_d.op    = p_q.op;
    s_d.as_re = p_q.as_re;
    s_d.as_im = p_q.as_im;
    s_d.den   = $unsigned(p_q.m4) + $unsigned(p_q.m5);
    if (p_q.op == OP_MUL) begin
      s_d.sre = SUM_BITS'(p_q.m0) - SUM_BITS'(p_q.m1);
      s_d.sim = SUM_BITS'(p_q.m3) + SUM_BITS'(p_q.m2);
    end else begin
      s_d.sre = SUM_BITS'(p_q.m0) + SUM_BITS'(p_q.m1);
      s_d.sim = SUM_BITS'(p_q.m2) - SUM_BITS'(p_q.m3);
    end
  end

  // sign and magnitude
  always_comb begin
    logic [AS_BITS-1:0]  t_re, t_im;
    logic [SUM_BITS-1:0] u_re, u_im;
    a_d.op       = s_q.op;
    a_d.den      = s_q.den;
    a_d.den_zero = s_q.den == '0;
    t_re = s_q.as_re[AS_BITS-1] ? AS_BITS'(-s_q.as_re) : s_q.as_re;
    t_im = s_q.as_im[AS_BITS-1] ? AS_BITS'(-s_q.as_im) : s_q.as_im;
    u_re = s_q.sre[SUM_BITS-1] ? SUM_BITS'(-s_q.sre) : s_q.sre;
    u_im = s_q.sim[SUM_BITS-1] ? SUM_BITS'(-s_q.sim) : s_q.sim;
    if (s_q.op == OP_ADD || s_q.op == OP_SUB) begin
      a_d.neg_re = s_q.as_re[AS_BITS-1];
      a_d.neg_im = s_q.as_im[AS_BITS-1];
      a_d.mag_re = PROD_BITS'(t_re);
      a_d.mag_im = PROD_BITS'(t_im);
    end else begin
      a_d.neg_re = s_q.sre[SUM_BITS-1];
      a_d.neg_im = s_q.sim[SUM_BITS-1];
      a_d.mag_re = u_re[PROD_BITS-1:0];
      a_d.mag_im = u_im[PROD_BITS-1:0];
    end
  end

  // multiply rounding, divider and root setup
  always_comb begin
    logic [PROD_BITS:0]     r_re, r_im;
    logic [DIVD_BITS-1:0]   d_re, d_im;
    o_d          = '0;
    o_d.op       = a_q.op;
    o_d.den_zero = a_q.den_zero;
    o_d.neg_re   = a_q.neg_re;
    o_d.neg_im   = a_q.neg_im;
    o_d.den      = a_q.den;
    r_re = ((PROD_BITS+1)'(a_q.mag_re) + HALF) >> FRAC_BITS;
    r_im = ((PROD_BITS+1)'(a_q.mag_im) + HALF) >> FRAC_BITS;
    if (a_q.op == OP_MUL) begin
      o_d.big_re = |r_re[PROD_BITS:QUO_BITS];
      o_d.big_im = |r_im[PROD_BITS:QUO_BITS];
      o_d.mag_re = r_re[QUO_BITS-1:0];
      o_d.mag_im = r_im[QUO_BITS-1:0];
    end else begin
      o_d.mag_re = a_q.mag_re[QUO_BITS-1:0];
      o_d.mag_im = a_q.mag_im[QUO_BITS-1:0];
    end
    // dividend is the magnitude with one guard bit below the fraction
    d_re = DIVD_BITS'(a_q.mag_re) << (FRAC_BITS + 1);
    d_im = DIVD_BITS'(a_q.mag_im) << (FRAC_BITS + 1);
    o_d.rem_re = PROD_BITS'(d_re[DIVD_BITS-1:QUO_BITS]);
    o_d.rem_im = PROD_BITS'(d_im[DIVD_BITS-1:QUO_BITS]);
    o_d.low_re = d_re[QUO_BITS-1:0];
    o_d.low_im = d_im[QUO_BITS-1:0];
    // quotient would not fit the iteration count: saturates for sure
    o_d.ovf_re = o_d.rem_re >= a_q.den;
    o_d.ovf_im = o_d.rem_im >= a_q.den;
    o_d.srad   = a_q.mag_re;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      sv_q <= 1'b0;
      av_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      pv_q <= valid_i;
      sv_q <= pv_q;
      av_q <= sv_q;
      ov_q <= av_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    s_q <= s_d;
    a_q <= a_d;
    o_q <= o_d;
  end

  assign valid_o = ov_q;
  assign stage_o = o_q;

endmodule

### rtl/cau_iter.sv
// ----------------------------------------------------------------------------
// cau_iter
// pipelined restoring divide and square root, rounding and saturation
// ----------------------------------------------------------------------------
module cau_iter import cau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  stage_t               stage_i,
  output logic                 done_o,
  output word_t                res_re_o,
  output word_t                res_im_o,
  output logic [STAT_BITS-1:0] status_o
);

  typedef struct packed {
    logic  sat;
    word_t val;
  } clamp_t;

  // one quotient bit for each part, one root digit when enabled
  function automatic stage_t step(stage_t s, logic do_sqrt);
    logic [PROD_BITS:0]  rs_re, rs_im, dx;
    logic                ge_re, ge_im;
    logic [SRT_BITS+1:0] sx, trial;
    stage_t              t;
    t     = s;
    dx    = {1'b0, s.den};
    rs_re = {s.rem_re, s.low_re[QUO_BITS-1]};
    rs_im = {s.rem_im, s.low_im[QUO_BITS-1]};
    ge_re = rs_re >= dx;
    ge_im = rs_im >= dx;
    t.rem_re = ge_re ? PROD_BITS'(rs_re - dx) : rs_re[PROD_BITS-1:0];
    t.rem_im = ge_im ? PROD_BITS'(rs_im - dx) : rs_im[PROD_BITS-1:0];
    t.q_re   = {s.q_re[QUO_BITS-2:0], ge_re};
    t.q_im   = {s.q_im[QUO_BITS-2:0], ge_im};
    t.low_re = {s.low_re[QUO_BITS-2:0], 1'b0};
    t.low_im = {s.low_im[QUO_BITS-2:0], 1'b0};
    if (do_sqrt) begin
      sx    = {s.srem, s.srad[PROD_BITS-1 -: 2]};
      trial = (SRT_BITS+2)'({s.sroot, 2'b01});
      if (sx >= trial) begin
        t.srem  = SRT_BITS'(sx - trial);
        t.sroot = {s.sroot[WORD_BITS-2:0], 1'b1};
      end else begin
        t.srem  = sx[SRT_BITS-1:0];
        t.sroot = {s.sroot[WORD_BITS-2:0], 1'b0};
      end
      t.srad = s.srad << 2;
    end
    return t;
  endfunction

  function automatic clamp_t clamp(logic neg, logic big, logic [QUO_BITS-1:0] mag);
    logic [QUO_BITS-1:0] nv;
    clamp_t              c;
    nv = QUO_BITS'(0) - mag;
    c.sat = 1'b0;
    if (neg) begin
      if (big || mag > NEG_MAG) begin
        c.sat = 1'b1;
        c.val = WORD_MIN;
      end else begin
        c.val = nv[WORD_BITS-1:0];
      end
    end else begin
      if (big || mag > POS_MAX) begin
        c.sat = 1'b1;
        c.val = WORD_MAX;
      end else begin
        c.val = mag[WORD_BITS-1:0];
      end
    end
    return c;
  endfunction

  stage_t              st_q [QUO_BITS];
  stage_t              st_d [QUO_BITS];
  logic [QUO_BITS-1:0] v_q;
  stage_t              f;
  logic                done_q;
  word_t               re_q, im_q, re_d, im_d;
  status_e             status_q, status_d;

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_d[k] = step(stage_i, 1'b1);
    end else begin : g_next
      assign st_d[k] = step(st_q[k-1], 1'(k < WORD_BITS));
    end
    always_ff @(posedge clk_i) begin
      st_q[k] <= st_d[k];
    end
  end

  assign f = st_q[QUO_BITS-1];

  always_comb begin
    logic                neg_re, neg_im, big_re, big_im, dz;
    logic [QUO_BITS-1:0] mag_re, mag_im;
    logic [QUO_BITS:0]   qr_re, qr_im;
    clamp_t              c_re, c_im;
    neg_re = f.neg_re;
    neg_im = f.neg_im;
    big_re = f.big_re;
    big_im = f.big_im;
    mag_re = f.mag_re;
    mag_im = f.mag_im;
    dz     = 1'b0;
    qr_re  = (QUO_BITS+1)'(f.q_re) + (QUO_BITS+1)'(1);
    qr_im  = (QUO_BITS+1)'(f.q_im) + (QUO_BITS+1)'(1);
    unique case (f.op) inside
      OP_ADD, OP_SUB, OP_MUL: begin
      end
      OP_DIV: begin
        if (f.den_zero) begin
          dz     = 1'b1;
          neg_re = 1'b0;
          neg_im = 1'b0;
          big_re = 1'b0;
          big_im = 1'b0;
          mag_re = '0;
          mag_im = '0;
        end else begin
          big_re = f.ovf_re;
          big_im = f.ovf_im;
          mag_re = qr_re[QUO_BITS:1];
          mag_im = qr_im[QUO_BITS:1];
        end
      end
      OP_MAG: begin
        // remainder above the root means the exact root is past the half
        neg_re = 1'b0;
        neg_im = 1'b0;
        big_re = 1'b0;
        big_im = 1'b0;
        mag_re = QUO_BITS'(f.sroot) + QUO_BITS'(f.srem > SRT_BITS'(f.sroot));
        mag_im = '0;
      end
      default: begin
        neg_re = 1'b0;
        neg_im = 1'b0;
        big_re = 1'b0;
        big_im = 1'b0;
        mag_re = '0;
        mag_im = '0;
      end
    endcase
    c_re = clamp(neg_re, big_re, mag_re);
    c_im = clamp(neg_im, big_im, mag_im);
    re_d = c_re.val;
    im_d = c_im.val;
    if (dz) begin
      status_d = ST_DZ;
    end else if (c_re.sat || c_im.sat) begin
      status_d = ST_SAT;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[QUO_BITS-2:0], valid_i};
      done_q <= v_q[QUO_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    re_q     <= re_d;
    im_q     <= im_d;
    status_q <= status_d;
  end

  assign done_o   = done_q;
  assign res_re_o = re_q;
  assign res_im_o = im_q;
  assign status_o = status_q;

endmodule

### rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// add, subtract, multiply, divide and magnitude on signed q8.8 complex values
// ----------------------------------------------------------------------------
//
// channel   direction  handshake               payload
// request   in         start high, busy low    mode_i, a_re_i, a_im_i, b_re_i, b_im_i
// result    out        done_o for one cycle    res_re_o, res_im_o, status_o
//
// one transaction accepted per cycle, every mode, sustained
// an item passes the front register, the queue, the mac stages and the divider
//   and root pipeline that retires one quotient bit per stage (17 stages)
// reset clears valid and queue state only; no clearing pass, ready right after reset
// busy only rises when the front register is occupied and the queue is full,
//   which the never-stalling back end keeps from happening in practice
// results cannot be held off: the back end runs freely
//
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_BITS-1:0] mode_i,
  input  word_t                a_re_i,
  input  word_t                a_im_i,
  input  word_t                b_re_i,
  input  word_t                b_im_i,
  output logic                 done_o,
  output word_t                res_re_o,
  output word_t                res_im_o,
  output logic [STAT_BITS-1:0] status_o
);

  // front to queue
  logic   push;
  logic   q_full;
  item_t  front_item;
  // queue to back end
  logic   q_valid;
  item_t  q_item;
  // mac to iteration pipeline
  logic   mac_valid;
  stage_t mac_stage;

  // decode and hold one transaction
  cau_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .mode_i   (mode_i),
    .a_re_i   (a_re_i),
    .a_im_i   (a_im_i),
    .b_re_i   (b_re_i),
    .b_im_i   (b_im_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (front_item)
  );

  // decouples acceptance from the datapath
  cau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // products, sums and iteration setup
  cau_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (q_item),
    .valid_o (mac_valid),
    .stage_o (mac_stage)
  );

  // divide, root, rounding and saturation
  cau_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mac_valid),
    .stage_i  (mac_stage),
    .done_o   (done_o),
    .res_re_o (res_re_o),
    .res_im_o (res_im_o),
    .status_o (status_o)
  );

endmodule

### rtl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// port level checks of the complex arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module cau_checker import cau_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input word_t                res_re_o,
  input word_t                res_im_o,
  input logic [STAT_BITS-1:0] status_o
);

  logic re_pinned;
  logic im_pinned;

  assign re_pinned = res_re_o == WORD_MAX || res_re_o == WORD_MIN;
  assign im_pinned = res_im_o == WORD_MAX || res_im_o == WORD_MIN;

  // zero denominator gives a zero result
  `CAU_ASSERT(a_dz_zero, done_o && status_o == ST_DZ, res_re_o == '0 && res_im_o == '0)
  // a saturated result has a part pinned to a bound
  `CAU_ASSERT(a_sat_bound, done_o && status_o == ST_SAT, re_pinned || im_pinned)
  // every accepted transaction comes back on done_o, delayed by LATENCY
  `CAU_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done_o)
  // no result without a transaction behind it
  `CAU_ASSERT(a_no_spurious, done_o, $past(start && !busy, LATENCY))

endmodule

bind complex_arithmetic_unit cau_checker u_checker (.*);
